[rtl/core/rcq_pkg.sv]
// rcq_pkg: shared types and constants for the byte ring queue
// operation and status codes, chain command struct
// no dependencies
`timescale 1ns / 1ps

package rcq_pkg;

  localparam int unsigned CountW  = 5;
  localparam int unsigned DataW   = 8;
  localparam int unsigned KindW   = 3;
  localparam int unsigned StatusW = 2;
  localparam int unsigned PosW    = 5;
  localparam int unsigned AddrW   = 3;
  localparam int unsigned BusW    = 32;
  // largest capacity the 5-bit register can ask for
  localparam int unsigned CellMax = 31;

  typedef enum logic [KindW-1:0] {
    KIND_ENQUEUE = 3'd0,
    KIND_DEQUEUE = 3'd1,
    KIND_CLEAR   = 3'd2,
    KIND_INSERT  = 3'd3,
    KIND_REVERSE = 3'd4
  } kind_e;

  typedef enum logic [StatusW-1:0] {
    STATUS_OK      = 2'd0,
    STATUS_FULL    = 2'd1,
    STATUS_EMPTY   = 2'd2,
    STATUS_BAD_POS = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    CMD_HOLD   = 3'd0,
    CMD_PUSH   = 3'd1,
    CMD_POP    = 3'd2,
    CMD_INSERT = 3'd3,
    CMD_ROTATE = 3'd4
  } chain_cmd_e;

  typedef enum logic {
    ST_IDLE    = 1'b0,
    ST_REVERSE = 1'b1
  } state_e;

  // register address of the capacity register (word index)
  localparam logic REG_CAPACITY = 1'b0;

  // broadcast to every cell of the chain
  typedef struct packed {
    chain_cmd_e              cmd;
    logic [CountW-1:0]       mark;
    logic [DataW-1:0]        value;
  } chain_ctl_t;

endpackage

[rtl/core/char_ring_queue_with_jump_and_reverse.sv]
// char_ring_queue_with_jump_and_reverse: top level of the byte queue
// row of rcq_cell slots held packed oldest first, steered by rcq_ctrl
// depends on rcq_pkg, rcq_cell, rcq_ctrl
`timescale 1ns / 1ps

// Byte queue with enqueue, dequeue, clear, insert at a 1-based position and
// reverse. Bytes sit packed in a row of cells, oldest in cell 0; each cell
// loads from its left or right neighbor, the front cell or the broadcast
// value. Every accepted transfer yields one result transfer, registered in
// the accept cycle. Reverse of more than one held byte issues its result at
// once, then the chain rotates one byte per cycle, front byte to the end of
// a shrinking prefix, while no new transfer is taken. The capacity register
// (address 0) accepts 1..31, 0 reads as 1, values above the built cell
// count are limited to it; a write empties the queue. Cells built: DEPTH,
// at most 31.
module char_ring_queue_with_jump_and_reverse #(
  parameter int unsigned DEPTH = 16
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [rcq_pkg::KindW-1:0]   kind_i,
  input  logic [rcq_pkg::DataW-1:0]   value_i,
  input  logic [rcq_pkg::PosW-1:0]    position_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [rcq_pkg::DataW-1:0]   data_o,
  output logic [rcq_pkg::StatusW-1:0] status_o,
  output logic [rcq_pkg::CountW-1:0]  fill_level_o,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [rcq_pkg::AddrW-1:0]   paddr,
  input  logic [rcq_pkg::BusW-1:0]    pwdata,
  output logic [rcq_pkg::BusW-1:0]    prdata,
  output logic                        pready
);

  localparam int unsigned NumCells = (DEPTH < rcq_pkg::CellMax) ? DEPTH : rcq_pkg::CellMax;

  rcq_pkg::chain_ctl_t        ctl;
  logic [rcq_pkg::DataW-1:0]  cell_byte [NumCells];

  // control and result register
  rcq_ctrl #(
    .NumCells (NumCells)
  ) u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .kind_i       (kind_i),
    .value_i      (value_i),
    .position_i   (position_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .data_o       (data_o),
    .status_o     (status_o),
    .fill_level_o (fill_level_o),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .front_i      (cell_byte[0]),
    .ctl_o        (ctl)
  );

  // chain of slots, each wired to its neighbors
  for (genvar g = 0; g < NumCells; g++) begin : g_cell
    logic [rcq_pkg::DataW-1:0] prev_byte;
    logic [rcq_pkg::DataW-1:0] next_byte;

    if (g == 0) begin : g_first
      assign prev_byte = '0;
    end else begin : g_mid_prev
      assign prev_byte = cell_byte[g-1];
    end

    if (g == NumCells - 1) begin : g_last
      assign next_byte = '0;
    end else begin : g_mid_next
      assign next_byte = cell_byte[g+1];
    end

    rcq_cell #(
      .Index (g)
    ) u_cell (
      .clk_i   (clk_i),
      .ctl_i   (ctl),
      .prev_i  (prev_byte),
      .next_i  (next_byte),
      .front_i (cell_byte[0]),
      .byte_o  (cell_byte[g])
    );
  end

endmodule

[rtl/core/rcq_cell.sv]
// rcq_cell: one byte slot of the packed queue chain
// takes its neighbors' bytes or the broadcast value on each command
// depends on rcq_pkg
`timescale 1ns / 1ps

module rcq_cell #(
  parameter int unsigned Index = 0
) (
  input  logic                     clk_i,
  input  rcq_pkg::chain_ctl_t      ctl_i,
  input  logic [rcq_pkg::DataW-1:0] prev_i,
  input  logic [rcq_pkg::DataW-1:0] next_i,
  input  logic [rcq_pkg::DataW-1:0] front_i,
  output logic [rcq_pkg::DataW-1:0] byte_o
);

  localparam logic [rcq_pkg::CountW-1:0] Idx = rcq_pkg::CountW'(Index);

  logic [rcq_pkg::DataW-1:0] byte_d, byte_q;

  // local decision from the broadcast command and this slot's place
  always_comb begin
    byte_d = byte_q;
    case (ctl_i.cmd)
      rcq_pkg::CMD_PUSH: begin
        if (Idx == ctl_i.mark) byte_d = ctl_i.value;
      end
      rcq_pkg::CMD_POP: begin
        byte_d = next_i;
      end
      rcq_pkg::CMD_INSERT: begin
        if (Idx == ctl_i.mark) begin
          byte_d = ctl_i.value;
        end else if (Idx > ctl_i.mark) begin
          byte_d = prev_i;
        end
      end
      rcq_pkg::CMD_ROTATE: begin
        if (Idx < ctl_i.mark) begin
          byte_d = next_i;
        end else if (Idx == ctl_i.mark) begin
          byte_d = front_i;
        end
      end
      default: byte_d = byte_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    byte_q <= byte_d;
  end

  assign byte_o = byte_q;

endmodule

[rtl/core/rcq_ctrl.sv]
// rcq_ctrl: queue control, fill count, capacity register and result register
// drives the command broadcast to the cell chain
// depends on rcq_pkg
`timescale 1ns / 1ps

module rcq_ctrl #(
  parameter int unsigned NumCells = 16
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [rcq_pkg::KindW-1:0]   kind_i,
  input  logic [rcq_pkg::DataW-1:0]   value_i,
  input  logic [rcq_pkg::PosW-1:0]    position_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [rcq_pkg::DataW-1:0]   data_o,
  output logic [rcq_pkg::StatusW-1:0] status_o,
  output logic [rcq_pkg::CountW-1:0]  fill_level_o,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [rcq_pkg::AddrW-1:0]   paddr,
  input  logic [rcq_pkg::BusW-1:0]    pwdata,
  output logic [rcq_pkg::BusW-1:0]    prdata,
  output logic                        pready,
  input  logic [rcq_pkg::DataW-1:0]   front_i,
  output rcq_pkg::chain_ctl_t         ctl_o
);

  localparam logic [rcq_pkg::CountW-1:0] CapMax   = rcq_pkg::CountW'(NumCells);
  localparam logic [rcq_pkg::CountW-1:0] CapReset =
    (NumCells < 16) ? rcq_pkg::CountW'(NumCells) : rcq_pkg::CountW'(16);
  localparam logic [rcq_pkg::CountW-1:0] One = rcq_pkg::CountW'(1);

  rcq_pkg::state_e state_d, state_q;
  logic [rcq_pkg::CountW-1:0]  count_d, count_q;
  logic [rcq_pkg::CountW-1:0]  cap_d, cap_q;
  logic [rcq_pkg::CountW-1:0]  span_d, span_q;
  logic                        out_valid_d, out_valid_q;
  logic [rcq_pkg::DataW-1:0]   data_d, data_q;
  rcq_pkg::status_e            status_d, status_q;
  logic [rcq_pkg::CountW-1:0]  fill_d, fill_q;

  logic                        accept;
  logic                        cfg_write;
  logic [rcq_pkg::CountW-1:0]  wr_cap;
  logic [rcq_pkg::CountW:0]    pos_ext;
  logic [rcq_pkg::CountW:0]    pos_limit;
  logic                        is_full;
  logic                        is_empty;

  assign in_ready_o = (state_q == rcq_pkg::ST_IDLE) && (!out_valid_q || out_ready_i);
  assign accept     = in_valid_i && in_ready_o;
  assign is_full    = (count_q >= cap_q);
  assign is_empty   = (count_q == '0);
  assign pos_ext    = {1'b0, position_i};
  assign pos_limit  = {1'b0, count_q} + {{rcq_pkg::CountW{1'b0}}, 1'b1};

  // register port
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && (paddr[2] == rcq_pkg::REG_CAPACITY);
  always_comb begin
    wr_cap = pwdata[rcq_pkg::CountW-1:0];
    if (wr_cap == '0) begin
      wr_cap = One;
    end else if (wr_cap > CapMax) begin
      wr_cap = CapMax;
    end
  end
  assign prdata = (paddr[2] == rcq_pkg::REG_CAPACITY) ?
                  {{(rcq_pkg::BusW - rcq_pkg::CountW){1'b0}}, cap_q} : '0;

  // next state
  always_comb begin
    state_d = state_q;
    span_d  = span_q;
    unique case (state_q)
      rcq_pkg::ST_IDLE: begin
        if (accept && (rcq_pkg::kind_e'(kind_i) == rcq_pkg::KIND_REVERSE)
            && (count_q > One)) begin
          state_d = rcq_pkg::ST_REVERSE;
          span_d  = count_q - One;
        end
      end
      rcq_pkg::ST_REVERSE: begin
        span_d = span_q - One;
        if (span_q == One) state_d = rcq_pkg::ST_IDLE;
      end
      default: state_d = rcq_pkg::ST_IDLE;
    endcase
  end

  // chain command, count and result
  always_comb begin
    ctl_o.cmd   = rcq_pkg::CMD_HOLD;
    ctl_o.mark  = count_q;
    ctl_o.value = value_i;
    count_d     = count_q;
    cap_d       = cap_q;
    data_d      = data_q;
    status_d    = status_q;
    fill_d      = fill_q;
    out_valid_d = out_valid_q;
    if (out_ready_i) out_valid_d = 1'b0;

    if (state_q == rcq_pkg::ST_REVERSE) begin
      // move the front byte to the end of the shrinking prefix
      ctl_o.cmd  = rcq_pkg::CMD_ROTATE;
      ctl_o.mark = span_q;
    end else if (accept) begin
      out_valid_d = 1'b1;
      data_d      = '0;
      status_d    = rcq_pkg::STATUS_OK;
      case (rcq_pkg::kind_e'(kind_i))
        rcq_pkg::KIND_ENQUEUE: begin
          if (is_full) begin
            status_d = rcq_pkg::STATUS_FULL;
          end else begin
            ctl_o.cmd = rcq_pkg::CMD_PUSH;
            count_d   = count_q + One;
          end
        end
        rcq_pkg::KIND_DEQUEUE: begin
          if (is_empty) begin
            status_d = rcq_pkg::STATUS_EMPTY;
          end else begin
            data_d    = front_i;
            ctl_o.cmd = rcq_pkg::CMD_POP;
            count_d   = count_q - One;
          end
        end
        rcq_pkg::KIND_CLEAR: begin
          if (is_empty) status_d = rcq_pkg::STATUS_EMPTY;
          count_d = '0;
        end
        rcq_pkg::KIND_INSERT: begin
          if ((position_i == '0) || (pos_ext > pos_limit)) begin
            status_d = rcq_pkg::STATUS_BAD_POS;
          end else if (is_full) begin
            status_d = rcq_pkg::STATUS_FULL;
          end else begin
            ctl_o.cmd  = rcq_pkg::CMD_INSERT;
            ctl_o.mark = position_i - One;
            count_d    = count_q + One;
          end
        end
        rcq_pkg::KIND_REVERSE: begin
          if (is_empty) status_d = rcq_pkg::STATUS_EMPTY;
        end
        default: status_d = rcq_pkg::STATUS_OK;
      endcase
      fill_d = count_d;
    end

    // capacity write empties the queue
    if (cfg_write) begin
      cap_d   = wr_cap;
      count_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= rcq_pkg::ST_IDLE;
      count_q     <= '0;
      cap_q       <= CapReset;
      span_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      cap_q       <= cap_d;
      span_q      <= span_d;
      out_valid_q <= out_valid_d;
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    data_q   <= data_d;
    status_q <= status_d;
    fill_q   <= fill_d;
  end

  assign out_valid_o  = out_valid_q;
  assign data_o       = data_q;
  assign status_o     = status_q;
  assign fill_level_o = fill_q;

endmodule

[tb/tb_top.sv]
// tb_top: self-checking bench for the byte ring queue with jump-insert and reverse
// directed table then random phases over several capacities, apb capacity writes
// depends on rcq_pkg and char_ring_queue_with_jump_and_reverse
`timescale 1ns / 1ps

module tb_top;

  localparam int unsigned SLOTS         = 16;
  // reverse keeps the block busy after its result while the chain rotates
  localparam int unsigned SETTLE_CYCLES = 40;
  localparam int unsigned CYCLE_LIMIT   = 400000;
  localparam int unsigned PHASES        = 8;
  localparam int unsigned PHASE_ITEMS   = 55;
  localparam int unsigned SQUEEZE_LEN   = 120;
  localparam int unsigned PRINT_CAP     = 100;
  localparam int unsigned TABLE_ROWS    = 27;

  localparam logic [rcq_pkg::KindW-1:0] KIND_SPARE_LO  = 3'd5;
  localparam logic [rcq_pkg::KindW-1:0] KIND_SPARE_MID = 3'd6;
  localparam logic [rcq_pkg::KindW-1:0] KIND_SPARE_HI  = 3'd7;
  localparam logic [rcq_pkg::AddrW-1:0] CAP_ADDR       = {rcq_pkg::REG_CAPACITY, 2'b00};

  typedef enum logic {ROW_ITEM, ROW_CAP_WRITE} row_e;

  typedef struct packed {
    logic [rcq_pkg::DataW-1:0]  data;
    rcq_pkg::status_e           status;
    logic [rcq_pkg::CountW-1:0] fill;
  } queue_result_t;

  typedef struct {
    row_e                       row;
    logic [rcq_pkg::KindW-1:0]  kind;
    logic [rcq_pkg::DataW-1:0]  value;
    logic [rcq_pkg::PosW-1:0]   pos;
    logic [rcq_pkg::CountW-1:0] cap;
    bit                         typed;
    logic [rcq_pkg::DataW-1:0]  data;
    rcq_pkg::status_e           status;
    logic [rcq_pkg::CountW-1:0] fill;
  } stim_row_t;

  logic                         clk_i        = 1'b0;
  logic                         rst_ni       = 1'b0;
  logic                         in_valid_i   = 1'b0;
  logic                         in_ready_o;
  logic [rcq_pkg::KindW-1:0]    kind_i       = '0;
  logic [rcq_pkg::DataW-1:0]    value_i      = '0;
  logic [rcq_pkg::PosW-1:0]     position_i   = '0;
  logic                         out_valid_o;
  logic                         out_ready_i  = 1'b0;
  logic [rcq_pkg::DataW-1:0]    data_o;
  logic [rcq_pkg::StatusW-1:0]  status_o;
  logic [rcq_pkg::CountW-1:0]   fill_level_o;
  logic                         psel         = 1'b0;
  logic                         penable      = 1'b0;
  logic                         pwrite       = 1'b0;
  logic [rcq_pkg::AddrW-1:0]    paddr        = '0;
  logic [rcq_pkg::BusW-1:0]     pwdata       = '0;
  logic [rcq_pkg::BusW-1:0]     prdata;
  logic                         pready;

  // predictor state: bytes held oldest first and the ring size in use
  logic [rcq_pkg::DataW-1:0]    held_bytes[$];
  int unsigned                  slot_limit = SLOTS;
  queue_result_t                pending_results[$];

  int unsigned         mismatch_count = 0;
  int unsigned         result_count   = 0;
  int unsigned         cycle_count    = 0;
  bit                  sender_steady  = 1'b0;
  bit                  squeeze_req    = 1'b0;
  bit                  squeeze_done   = 1'b0;

  // directed rows: queue starts at capacity 16, later shrunk to one slot
  stim_row_t stim_table [TABLE_ROWS] = '{
    '{ROW_ITEM, rcq_pkg::KIND_DEQUEUE, 8'h00, 5'd0, 5'd0,
      1'b1, 8'h00, rcq_pkg::STATUS_EMPTY, 5'd0},
    '{ROW_ITEM, rcq_pkg::KIND_REVERSE, 8'h00, 5'd0, 5'd0,
      1'b1, 8'h00, rcq_pkg::STATUS_EMPTY, 5'd0},
    '{ROW_ITEM, rcq_pkg::KIND_CLEAR, 8'h00, 5'd0, 5'd0,
      1'b1, 8'h00, rcq_pkg::STATUS_EMPTY, 5'd0},
    '{ROW_ITEM, rcq_pkg::KIND_INSERT, 8'hFF, 5'd0, 5'd0,
      1'b1, 8'h00, rcq_pkg::STATUS_BAD_POS, 5'd0},
    '{ROW_ITEM, rcq_pkg::KIND_INSERT, 8'hFF, 5'd2, 5'd0,
      1'b1, 8'h00, rcq_pkg::STATUS_BAD_POS, 5'd0},
    '{ROW_ITEM, rcq_pkg::KIND_INSERT, 8'hFF, 5'd1, 5'd0,
      1'b1, 8'h00, rcq_pkg::STATUS_OK, 5'd1},
    '{ROW_ITEM, rcq_pkg::KIND_ENQUEUE, 8'h00, 5'd0, 5'd0,
      1'b1, 8'h00, rcq_pkg::STATUS_OK, 5'd2},
    '{ROW_ITEM, rcq_pkg::KIND_ENQUEUE, 8'hA5, 5'd31, 5'd0,
      1'b0, 8'h00, rcq_pkg::STATUS_OK, 5'd0},
    '{ROW_ITEM, rcq_pkg::KIND_INSERT, 8'h5A, 5'd31, 5'd0,
      1'b1, 8'h00, rcq_pkg::STATUS_BAD_POS, 5'd3},
    '{ROW_ITEM, rcq_pkg::KIND_INSERT, 8'h3C, 5'd4, 5'd0,
      1'b0, 8'h00, rcq_pkg::STATUS_OK, 5'd0},
    '{ROW_ITEM, rcq_pkg::KIND_INSERT, 8'h81, 5'd2, 5'd0,
      1'b0, 8'h00, rcq_pkg::STATUS_OK, 5'd0},
    '{ROW_ITEM, rcq_pkg::KIND_REVERSE, 8'h00, 5'd0, 5'd0,
      1'b0, 8'h00, rcq_pkg::STATUS_OK, 5'd0},
    '{ROW_ITEM, rcq_pkg::KIND_DEQUEUE, 8'h00, 5'd0, 5'd0,
      1'b0, 8'h00, rcq_pkg::STATUS_OK, 5'd0},
    '{ROW_ITEM, KIND_SPARE_LO, 8'hFF, 5'd31, 5'd0,
      1'b0, 8'h00, rcq_pkg::STATUS_OK, 5'd0},
    '{ROW_ITEM, KIND_SPARE_MID, 8'h55, 5'd1, 5'd0,
      1'b0, 8'h00, rcq_pkg::STATUS_OK, 5'd0},
    '{ROW_ITEM, KIND_SPARE_HI, 8'h00, 5'd0, 5'd0,
      1'b0, 8'h00, rcq_pkg::STATUS_OK, 5'd0},
    '{ROW_ITEM, rcq_pkg::KIND_CLEAR, 8'h00, 5'd0, 5'd0,
      1'b1, 8'h00, rcq_pkg::STATUS_OK, 5'd0},
    '{ROW_CAP_WRITE, rcq_pkg::KIND_ENQUEUE, 8'h00, 5'd0, 5'd0,
      1'b0, 8'h00, rcq_pkg::STATUS_OK, 5'd0},
    '{ROW_ITEM, rcq_pkg::KIND_ENQUEUE, 8'h7E, 5'd0, 5'd0,
      1'b1, 8'h00, rcq_pkg::STATUS_OK, 5'd1},
    '{ROW_ITEM, rcq_pkg::KIND_ENQUEUE, 8'h01, 5'd0, 5'd0,
      1'b1, 8'h00, rcq_pkg::STATUS_FULL, 5'd1},
    '{ROW_ITEM, rcq_pkg::KIND_INSERT, 8'h02, 5'd2, 5'd0,
      1'b1, 8'h00, rcq_pkg::STATUS_FULL, 5'd1},
    '{ROW_ITEM, rcq_pkg::KIND_INSERT, 8'h03, 5'd3, 5'd0,
      1'b1, 8'h00, rcq_pkg::STATUS_BAD_POS, 5'd1},
    '{ROW_ITEM, rcq_pkg::KIND_REVERSE, 8'h00, 5'd0, 5'd0,
      1'b0, 8'h00, rcq_pkg::STATUS_OK, 5'd0},
    '{ROW_ITEM, rcq_pkg::KIND_DEQUEUE, 8'h00, 5'd0, 5'd0,
      1'b1, 8'h7E, rcq_pkg::STATUS_OK, 5'd0},
    '{ROW_ITEM, rcq_pkg::KIND_ENQUEUE, 8'h11, 5'd0, 5'd0,
      1'b0, 8'h00, rcq_pkg::STATUS_OK, 5'd0},
    '{ROW_CAP_WRITE, rcq_pkg::KIND_ENQUEUE, 8'h00, 5'd0, 5'd31,
      1'b0, 8'h00, rcq_pkg::STATUS_OK, 5'd0},
    '{ROW_ITEM, rcq_pkg::KIND_DEQUEUE, 8'h00, 5'd0, 5'd0,
      1'b1, 8'h00, rcq_pkg::STATUS_EMPTY, 5'd0}
  };

  char_ring_queue_with_jump_and_reverse #(
    .DEPTH(SLOTS)
  ) dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .kind_i      (kind_i),
    .value_i     (value_i),
    .position_i  (position_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .data_o      (data_o),
    .status_o    (status_o),
    .fill_level_o(fill_level_o),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  // 20 ns clock
  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // apply one operation to the held bytes and return what the block should answer
  function automatic queue_result_t apply_queue_op(
    input logic [rcq_pkg::KindW-1:0] kind,
    input logic [rcq_pkg::DataW-1:0] value,
    input logic [rcq_pkg::PosW-1:0]  pos
  );
    queue_result_t             res;
    logic [rcq_pkg::DataW-1:0] flipped[$];
    res.data   = '0;
    res.status = rcq_pkg::STATUS_OK;
    case (kind)
      rcq_pkg::KIND_ENQUEUE: begin
        if (held_bytes.size() >= slot_limit) res.status = rcq_pkg::STATUS_FULL;
        else held_bytes.push_back(value);
      end
      rcq_pkg::KIND_DEQUEUE: begin
        if (held_bytes.size() == 0) res.status = rcq_pkg::STATUS_EMPTY;
        else res.data = held_bytes.pop_front();
      end
      rcq_pkg::KIND_CLEAR: begin
        if (held_bytes.size() == 0) res.status = rcq_pkg::STATUS_EMPTY;
        held_bytes.delete();
      end
      rcq_pkg::KIND_INSERT: begin
        // position check wins over the full check
        if (pos == 0 || int'(pos) > held_bytes.size() + 1) begin
          res.status = rcq_pkg::STATUS_BAD_POS;
        end else if (held_bytes.size() >= slot_limit) begin
          res.status = rcq_pkg::STATUS_FULL;
        end else begin
          held_bytes.insert(int'(pos) - 1, value);
        end
      end
      rcq_pkg::KIND_REVERSE: begin
        if (held_bytes.size() == 0) begin
          res.status = rcq_pkg::STATUS_EMPTY;
        end else begin
          foreach (held_bytes[i]) flipped.push_front(held_bytes[i]);
          held_bytes = flipped;
        end
      end
      default: ;
    endcase
    res.fill = rcq_pkg::CountW'(held_bytes.size());
    return res;
  endfunction

  task automatic flag_mismatch(input string what, input int unsigned got,
                               input int unsigned want);
    mismatch_count++;
    if (mismatch_count <= PRINT_CAP)
      $display("mismatch at result %0d: %s got 0x%0h want 0x%0h", result_count, what,
               got, want);
  endtask

  // hold one operation until the block takes it, then record the expected answer
  task automatic send_item(input logic [rcq_pkg::KindW-1:0] kind,
                           input logic [rcq_pkg::DataW-1:0] value,
                           input logic [rcq_pkg::PosW-1:0] pos, input bit typed,
                           input queue_result_t typed_res);
    queue_result_t predicted;
    kind_i     <= kind;
    value_i    <= value;
    position_i <= pos;
    in_valid_i <= 1'b1;
    do begin
      @(posedge clk_i);
    end while (!in_ready_o);
    predicted = apply_queue_op(kind, value, pos);
    pending_results.push_back(typed ? typed_res : predicted);
  endtask

  // random sender gap, mostly none or short, sometimes long
  task automatic pause_sender();
    int unsigned roll;
    int unsigned gap;
    roll = $urandom_range(0, 99);
    if (sender_steady || roll < 50) gap = 0;
    else if (roll < 92) gap = $urandom_range(1, 3);
    else gap = $urandom_range(8, 30);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // capacity write over apb once the queue has gone quiet
  task automatic write_capacity(input logic [rcq_pkg::CountW-1:0] cap);
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= CAP_ADDR;
    pwdata  <= {{(rcq_pkg::BusW-rcq_pkg::CountW){1'b0}}, cap};
    @(posedge clk_i);
    penable <= 1'b1;
    do begin
      @(posedge clk_i);
    end while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    // zero acts as one slot, oversize values stop at the built depth
    if (cap == 0) slot_limit = 1;
    else if (cap > SLOTS) slot_limit = SLOTS;
    else slot_limit = 32'(cap);
    held_bytes.delete();
  endtask

  // result checker
  always @(posedge clk_i) begin : result_check
    queue_result_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_results.size() == 0) begin
        flag_mismatch("result with nothing pending, status", 32'(status_o), 0);
      end else begin
        want = pending_results.pop_front();
        if (data_o !== want.data)
          flag_mismatch("data", 32'(data_o), 32'(want.data));
        if (status_o !== want.status)
          flag_mismatch("status", 32'(status_o), 32'(want.status));
        if (fill_level_o !== want.fill)
          flag_mismatch("fill level", 32'(fill_level_o), 32'(want.fill));
      end
      result_count++;
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // receiver: steady runs, short stalls, rare long stalls, one long hold-off
  initial begin : receiver
    int unsigned pick;
    repeat (10) @(posedge clk_i);
    forever begin
      pick = $urandom_range(0, 99);
      if (squeeze_req && !squeeze_done) begin
        out_ready_i <= 1'b0;
        repeat (SQUEEZE_LEN) @(posedge clk_i);
        squeeze_done = 1'b1;
      end else if (pick < 25) begin
        out_ready_i <= 1'b1;
        repeat ($urandom_range(20, 60)) @(posedge clk_i);
      end else if (pick < 90) begin
        out_ready_i <= 1'b1;
        repeat ($urandom_range(1, 6)) @(posedge clk_i);
        out_ready_i <= 1'b0;
        repeat ($urandom_range(1, 3)) @(posedge clk_i);
      end else begin
        out_ready_i <= 1'b0;
        repeat ($urandom_range(10, 30)) @(posedge clk_i);
      end
    end
  end

  // sender: reset, directed table, then random phases at several capacities
  initial begin : sender
    logic [rcq_pkg::CountW-1:0] phase_caps [PHASES];
    queue_result_t              row_res;
    logic [rcq_pkg::KindW-1:0]  kind;
    logic [rcq_pkg::PosW-1:0]   pos;
    int unsigned                roll;
    int unsigned                row;
    int unsigned                ph;
    int unsigned                k;
    bit                         filling;
    phase_caps = '{5'd16, 5'd2, 5'd1, 5'd31, 5'd0, 5'd9, 5'd15, 5'd4};
    phase_caps[PHASES-1] = rcq_pkg::CountW'($urandom_range(0, 31));
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed table
    for (row = 0; row < TABLE_ROWS; row++) begin
      if (stim_table[row].row == ROW_CAP_WRITE) begin
        write_capacity(stim_table[row].cap);
      end else begin
        row_res.data   = stim_table[row].data;
        row_res.status = stim_table[row].status;
        row_res.fill   = stim_table[row].fill;
        send_item(stim_table[row].kind, stim_table[row].value, stim_table[row].pos,
                  stim_table[row].typed, row_res);
        pause_sender();
      end
    end

    // random phases: alternate fill-heavy and drain-heavy windows
    for (ph = 0; ph < PHASES; ph++) begin
      write_capacity(phase_caps[ph]);
      for (k = 0; k < PHASE_ITEMS; k++) begin
        filling = ((k / 16) % 2) == 0;
        if (k % 32 == 0) sender_steady = ($urandom_range(0, 3) == 0);
        if (ph == 0 && k == 20) squeeze_req = 1'b1;
        roll = $urandom_range(0, 99);
        if (filling) begin
          if (roll < 45) kind = rcq_pkg::KIND_ENQUEUE;
          else if (roll < 75) kind = rcq_pkg::KIND_INSERT;
          else if (roll < 85) kind = rcq_pkg::KIND_DEQUEUE;
          else if (roll < 93) kind = rcq_pkg::KIND_REVERSE;
          else if (roll < 95) kind = rcq_pkg::KIND_CLEAR;
          else kind = KIND_SPARE_LO + rcq_pkg::KindW'($urandom_range(0, 2));
        end else begin
          if (roll < 40) kind = rcq_pkg::KIND_DEQUEUE;
          else if (roll < 55) kind = rcq_pkg::KIND_ENQUEUE;
          else if (roll < 70) kind = rcq_pkg::KIND_INSERT;
          else if (roll < 85) kind = rcq_pkg::KIND_REVERSE;
          else if (roll < 92) kind = rcq_pkg::KIND_CLEAR;
          else kind = KIND_SPARE_LO + rcq_pkg::KindW'($urandom_range(0, 2));
        end
        // inserts mostly aim inside the queue, the rest anywhere in the field
        if (kind == rcq_pkg::KIND_INSERT && $urandom_range(0, 99) < 85)
          pos = rcq_pkg::PosW'($urandom_range(1, held_bytes.size() + 1));
        else
          pos = rcq_pkg::PosW'($urandom_range(0, 31));
        send_item(kind, rcq_pkg::DataW'($urandom_range(0, 255)), pos, 1'b0, '0);
        pause_sender();
      end
    end

    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

[files.f]
rtl/core/rcq_pkg.sv
rtl/core/rcq_cell.sv
rtl/core/rcq_ctrl.sv
rtl/core/char_ring_queue_with_jump_and_reverse.sv
tb/tb_top.sv
